### hw/rtl/vlt_pkg.sv
package vlt_pkg;

    localparam int DepthDefault = 32;
    localparam int DataW        = 32;
    localparam int OpW          = 3;
    localparam int StatusW      = 2;
    localparam int PosW         = 5;
    localparam int CntW         = 6;
    localparam int MaxRes       = 32;
    localparam int ResW         = $clog2(MaxRes);

    typedef enum logic [OpW-1:0] {
        OP_APPEND     = 3'd0,
        OP_SEARCH     = 3'd1,
        OP_REM_FIRST  = 3'd2,
        OP_REM_ALL    = 3'd3,
        OP_LIST       = 3'd4,
        OP_SORT_ASC   = 3'd5,
        OP_SORT_DESC  = 3'd6
    } t_op;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_PROC,
        S_RANK,
        S_DONE
    } t_state;

endpackage

### hw/rtl/value_list_table.sv
// Ordered list of up to DEPTH signed 32-bit entries with append, search, remove,
// list and sorted listing. The input channel (i_in_valid / o_in_ready) carries an
// operation code and a value; the output channel (o_out_valid / i_out_ready)
// returns one or more result transfers per input, the final one flagged by o_last.
// Entries sit in a single-port-read RAM; one sequencer walks them, visiting each
// entry with a read-address step and then a compare/move step. Search, list and
// remove scan the held entries once; sorting runs one full scan per rank.
// The input side is ready only when the sequencer is idle, so one operation runs
// at a time. Results pass through an output register, so the next input can be
// taken while the last result is still waiting. A stalled receiver stalls the
// scan only when a new result must be handed out and the output register is full.
// Reset clears the entry count; RAM contents are not cleared and never read
// beyond the count. At most 32 results are returned per input.
module value_list_table
    import vlt_pkg::*;
#(
    parameter int DEPTH = DepthDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OpW-1:0]            i_operation,
    input  logic signed [DataW-1:0]   i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [StatusW-1:0]        o_status,
    output logic [PosW-1:0]           o_position,
    output logic signed [DataW-1:0]   o_entry_value,
    output logic [CntW-1:0]           o_entry_count,
    output logic [CntW-1:0]           o_removed_count,
    output logic                      o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [DataW-1:0]  r_val, n_val;
    logic [AW-1:0]     r_rd, n_rd;
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_first, n_first;
    logic [AW-1:0]     r_rank, n_rank;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_n, n_n;
    logic [ResW-1:0]   r_nres, n_nres;

    logic              r_hold_vld, n_hold_vld;
    t_status           r_hold_status, n_hold_status;
    logic [AW-1:0]     r_hold_pos, n_hold_pos;
    logic [DataW-1:0]  r_hold_val, n_hold_val;
    logic [CW-1:0]     r_hold_rem, n_hold_rem;

    logic              r_prev_vld, n_prev_vld;
    logic [AW-1:0]     r_prev_pos, n_prev_pos;
    logic [DataW-1:0]  r_prev_val, n_prev_val;
    logic              r_best_vld, n_best_vld;
    logic [AW-1:0]     r_best_pos, n_best_pos;
    logic [DataW-1:0]  r_best_val, n_best_val;

    logic              r_ovalid;
    t_status           r_ostatus;
    logic [PosW-1:0]   r_opos;
    logic [DataW-1:0]  r_oval;
    logic [CntW-1:0]   r_ocnt;
    logic [CntW-1:0]   r_orem;
    logic              r_olast;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DataW-1:0]  ram_wdata;
    logic [DataW-1:0]  ram_rdata;

    logic              in_xfer;
    logic              out_free;
    logic              last_item;
    logic              is_remove;
    logic              is_sort;
    logic              is_desc;
    logic              match;
    logic              rem_take;
    logic              key_after;
    logic              key_better;
    logic              emit_req;
    logic [AW-1:0]     emit_pos;
    logic [DataW-1:0]  emit_val;
    logic              emit_push;
    logic              emit_stall;
    logic              emit_cap;
    logic              done_push;
    logic              push;

    vlt_ram #(
        .WIDTH (DataW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    // shared compare unit: entry under the read port against the list value,
    // the last emitted key and the best candidate of this rank
    always_comb begin
        in_xfer   = i_in_valid && (r_state == S_IDLE);
        out_free  = !r_ovalid || i_out_ready;
        last_item = (CW'(r_rd) + CW'(1)) == r_count;
        is_remove = (r_op == OP_REM_FIRST) || (r_op == OP_REM_ALL);
        is_sort   = (r_op == OP_SORT_ASC) || (r_op == OP_SORT_DESC);
        is_desc   = (r_op == OP_SORT_DESC);
        match     = ram_rdata == r_val;
        rem_take  = match && ((r_op == OP_REM_ALL) || (r_n == '0));
        if (!r_prev_vld) begin
            key_after = 1'b1;
        end else if (ram_rdata == r_prev_val) begin
            key_after = r_rd > r_prev_pos;
        end else if (is_desc) begin
            key_after = $signed(ram_rdata) < $signed(r_prev_val);
        end else begin
            key_after = $signed(ram_rdata) > $signed(r_prev_val);
        end
        if (!r_best_vld) begin
            key_better = 1'b1;
        end else if (is_desc) begin
            key_better = $signed(ram_rdata) > $signed(r_best_val);
        end else begin
            key_better = $signed(ram_rdata) < $signed(r_best_val);
        end
    end

    // result hand-off: a new result replaces the held one, which goes out first
    always_comb begin
        emit_req   = ((r_state == S_PROC) &&
                      (((r_op == OP_SEARCH) && match) || (r_op == OP_LIST))) ||
                     (r_state == S_RANK);
        emit_pos   = (r_state == S_RANK) ? r_best_pos : r_rd;
        emit_val   = (r_state == S_RANK) ? r_best_val : ram_rdata;
        emit_push  = emit_req && r_hold_vld && out_free;
        emit_stall = emit_req && r_hold_vld && !out_free;
        emit_cap   = emit_push && (r_nres == ResW'(MaxRes - 1));
        done_push  = (r_state == S_DONE) && out_free;
        push       = emit_push || done_push;
        o_in_ready = (r_state == S_IDLE);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr;
        ram_wdata = ram_rdata;
        if (in_xfer && (t_op'(i_operation) == OP_APPEND) && (r_count != CW'(DEPTH))) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[AW-1:0];
            ram_wdata = i_value;
        end else if ((r_state == S_PROC) && is_remove && !rem_take) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (t_op'(i_operation))
                        OP_APPEND: n_state = S_DONE;
                        OP_SEARCH, OP_REM_FIRST, OP_REM_ALL, OP_LIST,
                        OP_SORT_ASC, OP_SORT_DESC: begin
                            n_state = (r_count == '0) ? S_DONE : S_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: n_state = S_PROC;
            S_PROC: begin
                if (emit_stall) begin
                    n_state = S_PROC;
                end else if (emit_cap) begin
                    n_state = S_IDLE;
                end else if (last_item) begin
                    n_state = is_sort ? S_RANK : S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RANK: begin
                if (emit_stall) begin
                    n_state = S_RANK;
                end else if (emit_cap) begin
                    n_state = S_IDLE;
                end else if ((CW'(r_rank) + CW'(1)) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op          = r_op;
        n_val         = r_val;
        n_rd          = r_rd;
        n_wr          = r_wr;
        n_first       = r_first;
        n_rank        = r_rank;
        n_count       = r_count;
        n_n           = r_n;
        n_nres        = r_nres;
        n_hold_vld    = r_hold_vld;
        n_hold_status = r_hold_status;
        n_hold_pos    = r_hold_pos;
        n_hold_val    = r_hold_val;
        n_hold_rem    = r_hold_rem;
        n_prev_vld    = r_prev_vld;
        n_prev_pos    = r_prev_pos;
        n_prev_val    = r_prev_val;
        n_best_vld    = r_best_vld;
        n_best_pos    = r_best_pos;
        n_best_val    = r_best_val;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op          = t_op'(i_operation);
                    n_val         = i_value;
                    n_rd          = '0;
                    n_wr          = '0;
                    n_n           = '0;
                    n_rank        = '0;
                    n_nres        = '0;
                    n_prev_vld    = 1'b0;
                    n_best_vld    = 1'b0;
                    n_hold_vld    = 1'b0;
                    n_hold_status = ST_OK;
                    n_hold_pos    = '0;
                    n_hold_val    = '0;
                    n_hold_rem    = '0;
                    case (t_op'(i_operation))
                        OP_APPEND: begin
                            n_hold_vld = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_hold_status = ST_FULL;
                            end else begin
                                n_hold_pos = r_count[AW-1:0];
                                n_hold_val = i_value;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_REM_FIRST, OP_REM_ALL, OP_LIST, OP_SORT_ASC, OP_SORT_DESC: begin
                            if (r_count == '0) begin
                                n_hold_vld    = 1'b1;
                                n_hold_status = ST_EMPTY;
                            end
                        end
                        // search and unknown codes fall back to not found when nothing is held
                        default: n_hold_vld = 1'b0;
                    endcase
                end
            end
            S_PROC, S_RANK: begin
                if (emit_req && !emit_stall) begin
                    if (emit_cap) begin
                        n_hold_vld = 1'b0;
                    end else begin
                        if (r_hold_vld) begin
                            n_nres = r_nres + ResW'(1);
                        end
                        n_hold_vld    = 1'b1;
                        n_hold_status = ST_OK;
                        n_hold_pos    = emit_pos;
                        n_hold_val    = emit_val;
                        n_hold_rem    = '0;
                    end
                end
                if (r_state == S_PROC) begin
                    if (!emit_stall && !emit_cap && !last_item) begin
                        n_rd = r_rd + AW'(1);
                    end
                    if (is_remove) begin
                        if (rem_take) begin
                            n_n = r_n + CW'(1);
                            if (r_n == '0) begin
                                n_first = r_rd;
                            end
                        end else begin
                            n_wr = r_wr + AW'(1);
                        end
                        if (last_item) begin
                            n_count = r_count - n_n;
                            if (n_n != '0) begin
                                n_hold_vld    = 1'b1;
                                n_hold_status = ST_OK;
                                n_hold_pos    = n_first;
                                n_hold_val    = r_val;
                                n_hold_rem    = n_n;
                            end
                        end
                    end
                    if (is_sort && key_after && key_better) begin
                        n_best_vld = 1'b1;
                        n_best_pos = r_rd;
                        n_best_val = ram_rdata;
                    end
                end else if (!emit_stall && !emit_cap) begin
                    // advance to the next rank
                    n_prev_vld = 1'b1;
                    n_prev_pos = r_best_pos;
                    n_prev_val = r_best_val;
                    n_best_vld = 1'b0;
                    n_rank     = r_rank + AW'(1);
                    n_rd       = '0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_hold_vld = 1'b0;
                end
            end
            default: n_hold_vld = r_hold_vld;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_hold_vld <= 1'b0;
            r_prev_vld <= 1'b0;
            r_best_vld <= 1'b0;
            r_nres     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_hold_vld <= n_hold_vld;
            r_prev_vld <= n_prev_vld;
            r_best_vld <= n_best_vld;
            r_nres     <= n_nres;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_val         <= n_val;
        r_rd          <= n_rd;
        r_wr          <= n_wr;
        r_first       <= n_first;
        r_rank        <= n_rank;
        r_n           <= n_n;
        r_hold_status <= n_hold_status;
        r_hold_pos    <= n_hold_pos;
        r_hold_val    <= n_hold_val;
        r_hold_rem    <= n_hold_rem;
        r_prev_pos    <= n_prev_pos;
        r_prev_val    <= n_prev_val;
        r_best_pos    <= n_best_pos;
        r_best_val    <= n_best_val;
        if (push) begin
            if (done_push && !r_hold_vld) begin
                r_ostatus <= ST_NOT_FOUND;
                r_opos    <= '0;
                r_oval    <= '0;
                r_orem    <= '0;
            end else begin
                r_ostatus <= r_hold_status;
                r_opos    <= PosW'(r_hold_pos);
                r_oval    <= r_hold_val;
                r_orem    <= CntW'(r_hold_rem);
            end
            r_ocnt  <= CntW'(r_count);
            r_olast <= done_push || emit_cap;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_position      = r_opos;
    assign o_entry_value   = r_oval;
    assign o_entry_count   = r_ocnt;
    assign o_removed_count = r_orem;
    assign o_last          = r_olast;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROC) |-> (r_wr <= r_rd))
        else $error("compaction write ahead of read");

    a_we_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (in_xfer || (r_state == S_PROC)))
        else $error("entry write outside append or remove");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> r_ovalid)
        else $error("pending result dropped");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostatus != ST_OK)) |-> (r_olast && (r_orem == '0)))
        else $error("error result not single and final");

endmodule

### hw/rtl/vlt_ram.sv
module vlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
